/* rtl/motor_command_sequencer_assert.svh */
// Assertion macros for the motor command sequencer checker.
// Both macros expect clk and rst_n to be visible where they are used.
`ifndef MOTOR_COMMAND_SEQUENCER_ASSERT_SVH
`define MOTOR_COMMAND_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mcs_pkg.sv */
// Shared types, codes and helpers for the motor command sequencer.
// No dependencies; every other file but the assertion header imports this package.
`timescale 1ns / 1ps

package mcs_pkg;

    localparam int FRAME_LEN = 5;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);

    localparam logic [2:0] ACT_BYTE  = 3'd0;
    localparam logic [2:0] ACT_TICK  = 3'd1;
    localparam logic [2:0] ACT_ENC_A = 3'd2;
    localparam logic [2:0] ACT_ENC_B = 3'd3;
    localparam logic [2:0] ACT_LOAD  = 3'd4;

    // Drive sign patterns: AP = +gain_a, AN = -gain_a, likewise for B.
    localparam logic [7:0] MODE_AP_BN = 8'd1;
    localparam logic [7:0] MODE_AN_BN = 8'd2;
    localparam logic [7:0] MODE_AP_BP = 8'd3;
    localparam logic [7:0] MODE_AN_BP = 8'd4;
    localparam logic [7:0] MODE_CAL   = 8'd5;

    localparam logic [7:0] FRAME_HEADER = 8'hBB;

    localparam logic        CFG_GAIN_A = 1'b0;
    localparam logic        CFG_GAIN_B = 1'b1;

    localparam logic signed [15:0] GAIN_HIGH_LIMIT    = 16'sd4090;
    localparam logic signed [15:0] GAIN_HIGH_FALLBACK = 16'sd1000;
    localparam logic signed [15:0] GAIN_LOW_LIMIT     = 16'sd400;
    localparam logic [15:0]        GAIN_STORE_RESET   = 16'd1000;
    localparam logic [15:0]        GAIN_RESET         = 16'd400;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
    } mcs_in_t;

    typedef struct packed {
        logic signed [15:0] drive_a;
        logic signed [15:0] drive_b;
        logic               busy_res;
        logic               step_end;
        logic               save_now;
        logic signed [15:0] save_gain_a;
        logic signed [15:0] save_gain_b;
        logic               frame_rejected;
    } mcs_out_t;

    typedef struct packed {
        logic [2:0]  frame_fill;
        logic [7:0]  xor_accum;
        logic        running;
        logic [7:0]  step_time;
        logic [7:0]  step_target;
        logic [7:0]  repeats_left;
        logic [7:0]  step_mode;
        logic [7:0]  elapsed_ms;
        logic [15:0] gain_a;
        logic [15:0] gain_b;
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] match_streak;
    } mcs_state_t;

    localparam mcs_state_t STATE_RESET = '{
        frame_fill:   3'd0,
        xor_accum:    8'd0,
        running:      1'b0,
        step_time:    8'd0,
        step_target:  8'd0,
        repeats_left: 8'd0,
        step_mode:    8'd0,
        elapsed_ms:   8'd0,
        gain_a:       GAIN_RESET,
        gain_b:       GAIN_RESET,
        count_a:      16'd0,
        count_b:      16'd0,
        match_streak: 16'd0
    };

    typedef logic [FRAME_LEN-1:0][7:0] mcs_frame_t;

    // Frame byte buffer write request.
    typedef struct packed {
        logic                   we;
        logic [FRAME_IDX_W-1:0] idx;
    } mcs_fb_wr_t;

    // Gain sanity clamp applied on load.
    function automatic logic [15:0] check_gain(input logic [15:0] g);
        logic signed [15:0] s;
        s = signed'(g);
        if (s > GAIN_HIGH_LIMIT)
        begin
            s = GAIN_HIGH_FALLBACK;
        end
        if (s < GAIN_LOW_LIMIT)
        begin
            s = GAIN_LOW_LIMIT;
        end
        return unsigned'(s);
    endfunction

endpackage

/* rtl/mcs_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
// Depends on mcs_pkg for the default payload type.
`timescale 1ns / 1ps

interface mcs_stream_if
    import mcs_pkg::*;
#(
    parameter type payload_t = mcs_in_t
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/mcs_update.sv */
// Per-item state update and result computation (pure combinational).
// Depends on mcs_pkg.
`timescale 1ns / 1ps

module mcs_update
    import mcs_pkg::*;
(
    input  mcs_in_t    item,
    input  mcs_state_t cur,
    input  mcs_frame_t frame,
    input  logic [15:0] stored_gain_a,
    input  logic [15:0] stored_gain_b,
    output mcs_state_t nxt,
    output mcs_out_t   res,
    output mcs_fb_wr_t fb_wr
);

    logic [7:0]  elapsed_inc;
    logic [7:0]  repeats_dec;
    logic [15:0] drv_a;
    logic [15:0] drv_b;

    always_comb
    begin
        nxt         = cur;
        fb_wr       = '0;
        res         = '0;
        elapsed_inc = cur.elapsed_ms + 8'd1;
        repeats_dec = cur.repeats_left - 8'd1;

        unique case (item.action)
            ACT_BYTE:
            begin
                if (!cur.running)
                begin
                    if (cur.frame_fill < 3'(FRAME_LEN))
                    begin
                        fb_wr.we       = 1'b1;
                        fb_wr.idx      = FRAME_IDX_W'(cur.frame_fill);
                        nxt.xor_accum  = cur.xor_accum ^ item.data_byte;
                        nxt.frame_fill = cur.frame_fill + 3'd1;
                    end
                    else
                    begin
                        // Sixth byte is the check byte
                        if (frame[0] == FRAME_HEADER && cur.xor_accum == item.data_byte)
                        begin
                            nxt.step_time    = frame[1];
                            nxt.step_target  = frame[2];
                            nxt.repeats_left = frame[3];
                            nxt.step_mode    = frame[4];
                            nxt.elapsed_ms   = 8'd0;
                            if (frame[3] != 8'd0)
                            begin
                                nxt.running = 1'b1;
                            end
                            else if (frame[4] == MODE_CAL && cur.match_streak != 16'd0)
                            begin
                                res.save_now     = 1'b1;
                                res.save_gain_a  = cur.gain_a;
                                res.save_gain_b  = cur.gain_b;
                                nxt.match_streak = 16'd0;
                            end
                        end
                        else
                        begin
                            res.frame_rejected = 1'b1;
                        end
                        nxt.frame_fill = 3'd0;
                        nxt.xor_accum  = 8'd0;
                    end
                end
            end
            ACT_TICK:
            begin
                if (cur.running)
                begin
                    nxt.elapsed_ms = elapsed_inc;
                    if (elapsed_inc >= cur.step_time)
                    begin
                        res.step_end   = 1'b1;
                        nxt.elapsed_ms = 8'd0;
                        if (cur.step_mode == MODE_CAL)
                        begin
                            nxt.gain_a = cur.gain_a - cur.count_a + 16'(cur.step_target);
                            nxt.gain_b = cur.gain_b - cur.count_b + 16'(cur.step_target);
                            nxt.match_streak = (cur.count_a == cur.count_b) ?
                                               cur.match_streak + 16'd1 : 16'd0;
                            nxt.count_a = 16'd0;
                            nxt.count_b = 16'd0;
                        end
                        nxt.repeats_left = repeats_dec;
                        if (repeats_dec == 8'd0)
                        begin
                            nxt.running = 1'b0;
                            if (cur.step_mode == MODE_CAL && nxt.match_streak != 16'd0)
                            begin
                                res.save_now     = 1'b1;
                                res.save_gain_a  = nxt.gain_a;
                                res.save_gain_b  = nxt.gain_b;
                                nxt.match_streak = 16'd0;
                            end
                        end
                    end
                end
            end
            ACT_ENC_A:
            begin
                nxt.count_a = cur.count_a + 16'd1;
            end
            ACT_ENC_B:
            begin
                nxt.count_b = cur.count_b + 16'd1;
            end
            ACT_LOAD:
            begin
                nxt.gain_a = check_gain(stored_gain_a);
                nxt.gain_b = check_gain(stored_gain_b);
            end
            default:
            begin
                // unused action codes leave everything as is
            end
        endcase

        // Drive follows the state after this item
        drv_a = 16'd0;
        drv_b = 16'd0;
        if (nxt.running)
        begin
            case (nxt.step_mode) inside
                MODE_AP_BN, MODE_CAL:
                begin
                    drv_a = nxt.gain_a;
                    drv_b = 16'd0 - nxt.gain_b;
                end
                MODE_AN_BN:
                begin
                    drv_a = 16'd0 - nxt.gain_a;
                    drv_b = 16'd0 - nxt.gain_b;
                end
                MODE_AP_BP:
                begin
                    drv_a = nxt.gain_a;
                    drv_b = nxt.gain_b;
                end
                MODE_AN_BP:
                begin
                    drv_a = 16'd0 - nxt.gain_a;
                    drv_b = nxt.gain_b;
                end
                default:
                begin
                    drv_a = 16'd0;
                    drv_b = 16'd0;
                end
            endcase
        end
        res.drive_a  = signed'(drv_a);
        res.drive_b  = signed'(drv_b);
        res.busy_res = nxt.running;
    end

endmodule

/* rtl/motor_command_sequencer.sv */
// Top level of the motor command sequencer: handshake, state and result registers.
// Depends on mcs_pkg, mcs_stream_if and mcs_update.
`timescale 1ns / 1ps

// Motor command sequencer. Each input item is a received serial byte, a
// millisecond tick, an encoder A or B pulse, or a request to load the two
// gains from the stored_gain registers (clamped: above 4090 becomes 1000,
// below 400 becomes 400). Six-byte frames (0xBB, step time, step target,
// repeat count, mode, XOR of the first five) start a run when the repeat
// count is nonzero; bytes arriving during a run are dropped. Every item
// yields exactly one result item with the motor drives, busy flag,
// step-end and save strobes and frame reject. Throughput is one item per
// clock while the sink does not stall: an accepted item goes into the
// input register, where a single combinational update pass computes the
// new state and its result, then moves into the output register, which
// presents the result to the sink. The output register holds a result
// while the sink stalls, and the input register keeps taking items until
// both stages are full. No clearing pass is needed after reset.
// Configuration writes land directly in the stored gain registers and take
// effect at the next load item.

module motor_command_sequencer
    import mcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    mcs_stream_if.sink          in_ch,
    mcs_stream_if.source        out_ch,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    // Input stage
    logic       stage_valid_reg;
    logic       stage_valid_next;
    mcs_in_t    stage_item_reg;

    // Architectural state
    mcs_state_t state_reg;
    mcs_state_t state_next;
    mcs_frame_t frame_reg;      // payload only, judged after all bytes written

    // Stored gains (config registers)
    logic [15:0] stored_gain_a_reg;
    logic [15:0] stored_gain_b_reg;

    // Output stage
    logic       out_valid_reg;
    logic       out_valid_next;
    mcs_out_t   out_item_reg;
    mcs_out_t   result;

    mcs_fb_wr_t fb_wr;
    logic       in_take;
    logic       advance;

    // Stage moves forward when the output slot is free or draining now
    assign advance      = stage_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !stage_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    mcs_update u_update (
        .item          (stage_item_reg),
        .cur           (state_reg),
        .frame         (frame_reg),
        .stored_gain_a (stored_gain_a_reg),
        .stored_gain_b (stored_gain_b_reg),
        .nxt           (state_next),
        .res           (result),
        .fb_wr         (fb_wr)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= STATE_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_gain_a_reg <= GAIN_STORE_RESET;
            stored_gain_b_reg <= GAIN_STORE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_A:
                begin
                    stored_gain_a_reg <= cfg_data;
                end
                CFG_GAIN_B:
                begin
                    stored_gain_b_reg <= cfg_data;
                end
                default:
                begin
                    stored_gain_a_reg <= stored_gain_a_reg;
                end
            endcase
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_item_reg <= in_ch.payload;
        end
        if (advance)
        begin
            out_item_reg <= result;
            if (fb_wr.we)
            begin
                frame_reg[fb_wr.idx] <= stage_item_reg.data_byte;
            end
        end
    end

endmodule

/* rtl/mcs_checker.sv */
// Port-level checker for the motor command sequencer, bound to the top level.
// Depends on mcs_pkg and motor_command_sequencer_assert.svh.
`timescale 1ns / 1ps
`include "motor_command_sequencer_assert.svh"

module mcs_checker
    import mcs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input mcs_out_t out_payload
);

    logic out_stall;
    logic out_idle;
    logic out_save;
    logic out_nosave;
    logic out_reject;
    logic drive_zero;
    logic save_zero;
    logic save_alone;
    logic reject_alone;

    assign out_stall    = out_valid && !out_ready;
    assign out_idle     = out_valid && !out_payload.busy_res;
    assign out_save     = out_valid && out_payload.save_now;
    assign out_nosave   = out_valid && !out_payload.save_now;
    assign out_reject   = out_valid && out_payload.frame_rejected;
    assign drive_zero   = (out_payload.drive_a == 16'sd0) && (out_payload.drive_b == 16'sd0);
    assign save_zero    = (out_payload.save_gain_a == 16'sd0) &&
                          (out_payload.save_gain_b == 16'sd0);
    assign save_alone   = !out_payload.busy_res && !out_payload.frame_rejected;
    assign reject_alone = !out_payload.busy_res && !out_payload.step_end;

    `MCS_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(out_payload), "result not held")
    `MCS_ASSERT_SAME(a_idle_no_drive, out_idle, drive_zero, "drive while not busy")
    `MCS_ASSERT_SAME(a_save_ends_run, out_save, save_alone, "save during run")
    `MCS_ASSERT_SAME(a_save_gains_zero, out_nosave, save_zero, "save gains without save")
    `MCS_ASSERT_SAME(a_reject_alone, out_reject, reject_alone, "reject with run activity")

endmodule

bind motor_command_sequencer mcs_checker u_mcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
